@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// condition that holds every clock edge outside reset
`define ASSERT_ALW(label, clk, rst_n, a) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a)) \
		else $error("assertion failed");
`endif

@@ rtl/core/bdll_pkg.sv @@
// shared types and constants of the bounded linked list
`timescale 1ns / 1ps
package bdll_pkg;
	localparam int Capacity = 16;
	localparam int SlotW = $clog2(Capacity);
	localparam int CountW = $clog2(Capacity + 1);

	localparam logic [2:0] KIND_INS_HEAD = 3'd0;
	localparam logic [2:0] KIND_INS_TAIL = 3'd1;
	localparam logic [2:0] KIND_DEL_HEAD = 3'd2;
	localparam logic [2:0] KIND_DEL_TAIL = 3'd3;
	localparam logic [2:0] KIND_DEL_AT = 3'd4;
	localparam logic [2:0] KIND_DUMP_FWD = 3'd5;
	localparam logic [2:0] KIND_DUMP_BWD = 3'd6;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	// request as held in the queue between front and back
	typedef struct packed {
		logic [2:0] kind;
		logic signed [31:0] value;
		logic [3:0] position;
	} req_t;
endpackage

@@ rtl/core/bdll_front.sv @@
// front part: request intake queue of two entries
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bdll_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input bdll_pkg::req_t in_req,
	output logic q_valid,
	input logic q_ready,
	output bdll_pkg::req_t q_req
);
	bdll_pkg::req_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign in_ready = cnt_q != 2'd2;
	assign q_valid = cnt_q != 2'd0;
	assign q_req = mem_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wr_q] <= in_req;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (q_valid && q_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
		end
	end

	`ASSERT_ALW(a_cnt_range, clk, arst_n, cnt_q <= 2'd2)
	`ASSERT_IMP(a_ptr_eq, clk, arst_n, cnt_q == 2'd0 || cnt_q == 2'd2, wr_q == rd_q)
	`ASSERT_IMP(a_ptr_ne, clk, arst_n, cnt_q == 2'd1, wr_q != rd_q)
endmodule

@@ rtl/core/bdll_back.sv @@
// back part: list engine that walks the link memories
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bdll_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input bdll_pkg::req_t q_req,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic signed [31:0] element,
	output logic [4:0] count,
	output logic last
);
	localparam int SW = bdll_pkg::SlotW;
	localparam int CW = bdll_pkg::CountW;
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_FIX = 3'd2;
	localparam logic [2:0] S_DUMP = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;

	logic signed [31:0] val_mem [bdll_pkg::Capacity];
	logic [SW-1:0] fwd_mem [bdll_pkg::Capacity];
	logic [SW-1:0] bwd_mem [bdll_pkg::Capacity];
	logic [SW-1:0] free_mem [bdll_pkg::Capacity];

	logic [2:0] state_q;
	logic [SW-1:0] head_q, tail_q, cur_q;
	logic [CW-1:0] cnt_q, free_top_q, step_q;
	logic [CW-1:0] init_q;
	logic dir_q;
	bdll_pkg::req_t req_q;

	logic [SW-1:0] rd_fwd, rd_bwd;
	logic [SW-1:0] nxt_slot;
	logic [SW-1:0] new_slot;
	logic fire;

	// combinational reads of small register files: links at the walking address, free stack at its top
	assign rd_fwd = fwd_mem[cur_q];
	assign rd_bwd = bwd_mem[cur_q];
	assign nxt_slot = dir_q ? rd_fwd : rd_bwd;
	assign new_slot = free_mem[SW'(free_top_q - CW'(1))];

	assign q_ready = (state_q == S_IDLE) && (init_q == CW'(bdll_pkg::Capacity));
	assign out_valid = state_q == S_OUT || state_q == S_DUMP;

	assign fire = q_valid && q_ready;

	// free stack fill after reset, then list engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
			free_top_q <= CW'(bdll_pkg::Capacity);
			init_q <= '0;
			cur_q <= '0;
			step_q <= '0;
			dir_q <= 1'b0;
		end else begin
			if (init_q != CW'(bdll_pkg::Capacity)) init_q <= init_q + CW'(1);
			unique case (state_q)
				S_IDLE: begin
					if (fire) begin
						status <= bdll_pkg::ST_OK;
						element <= '0;
						last <= 1'b1;
						state_q <= S_OUT;
						count <= 5'(cnt_q);
						unique case (q_req.kind)
							bdll_pkg::KIND_INS_HEAD, bdll_pkg::KIND_INS_TAIL: begin
								if (cnt_q == CW'(bdll_pkg::Capacity)) begin
									status <= bdll_pkg::ST_FULL;
								end else begin
									free_top_q <= free_top_q - CW'(1);
									cnt_q <= cnt_q + CW'(1);
									count <= 5'(cnt_q + CW'(1));
									if (cnt_q == '0) begin
										head_q <= new_slot;
										tail_q <= new_slot;
									end else if (q_req.kind == bdll_pkg::KIND_INS_HEAD) begin
										head_q <= new_slot;
									end else begin
										tail_q <= new_slot;
									end
								end
							end
							bdll_pkg::KIND_DEL_HEAD, bdll_pkg::KIND_DEL_TAIL,
							bdll_pkg::KIND_DEL_AT: begin
								if (cnt_q == '0) begin
									status <= bdll_pkg::ST_EMPTY;
								end else if (q_req.kind == bdll_pkg::KIND_DEL_AT &&
										CW'(q_req.position) >= cnt_q) begin
									status <= bdll_pkg::ST_RANGE;
								end else begin
									cur_q <= head_q;
									step_q <= CW'(q_req.position);
									if (q_req.kind == bdll_pkg::KIND_DEL_TAIL ||
											(q_req.kind == bdll_pkg::KIND_DEL_AT &&
											CW'(q_req.position) == cnt_q - CW'(1)))
										cur_q <= tail_q;
									if (q_req.kind == bdll_pkg::KIND_DEL_AT &&
											q_req.position != '0 &&
											CW'(q_req.position) != cnt_q - CW'(1))
										state_q <= S_WALK;
									else
										state_q <= S_FIX;
								end
							end
							bdll_pkg::KIND_DUMP_FWD, bdll_pkg::KIND_DUMP_BWD: begin
								if (cnt_q == '0) begin
									status <= bdll_pkg::ST_EMPTY;
								end else begin
									dir_q <= q_req.kind == bdll_pkg::KIND_DUMP_FWD;
									cur_q <= (q_req.kind == bdll_pkg::KIND_DUMP_FWD) ? head_q : tail_q;
									element <= (q_req.kind == bdll_pkg::KIND_DUMP_FWD) ?
										val_mem[head_q] : val_mem[tail_q];
									last <= cnt_q == CW'(1);
									step_q <= cnt_q;
									state_q <= S_DUMP;
								end
							end
							default: ;
						endcase
						req_q <= q_req;
					end
				end
				// walk the forward links to the position
				S_WALK: begin
					if (step_q == '0) state_q <= S_FIX;
					else begin
						cur_q <= rd_fwd;
						step_q <= step_q - CW'(1);
					end
				end
				// unlink the slot under the cursor
				S_FIX: begin
					free_top_q <= free_top_q + CW'(1);
					cnt_q <= cnt_q - CW'(1);
					count <= 5'(cnt_q - CW'(1));
					if (cnt_q == CW'(1)) begin
						head_q <= '0;
						tail_q <= '0;
					end else if (cur_q == head_q && req_q.kind != bdll_pkg::KIND_DEL_TAIL &&
							!(req_q.kind == bdll_pkg::KIND_DEL_AT && req_q.position != '0)) begin
						head_q <= rd_fwd;
					end else if (req_q.kind == bdll_pkg::KIND_DEL_TAIL ||
							(req_q.kind == bdll_pkg::KIND_DEL_AT &&
							CW'(req_q.position) == cnt_q - CW'(1))) begin
						tail_q <= rd_bwd;
					end
					state_q <= S_OUT;
				end
				// stream one entry per reply taken, next entry loaded ahead
				S_DUMP: begin
					if (out_ready) begin
						cur_q <= nxt_slot;
						step_q <= step_q - CW'(1);
						if (step_q == CW'(1)) begin
							state_q <= S_IDLE;
						end else begin
							element <= val_mem[nxt_slot];
							last <= step_q == CW'(2);
						end
					end
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (init_q != CW'(bdll_pkg::Capacity)) free_mem[SW'(init_q)] <= SW'(init_q);
		if (state_q == S_IDLE && fire && cnt_q != CW'(bdll_pkg::Capacity) &&
				(q_req.kind == bdll_pkg::KIND_INS_HEAD || q_req.kind == bdll_pkg::KIND_INS_TAIL)) begin
			val_mem[new_slot] <= q_req.value;
			if (cnt_q == '0) begin
				fwd_mem[new_slot] <= '0;
				bwd_mem[new_slot] <= '0;
			end else if (q_req.kind == bdll_pkg::KIND_INS_HEAD) begin
				fwd_mem[new_slot] <= head_q;
				bwd_mem[new_slot] <= '0;
				bwd_mem[head_q] <= new_slot;
			end else begin
				bwd_mem[new_slot] <= tail_q;
				fwd_mem[new_slot] <= '0;
				fwd_mem[tail_q] <= new_slot;
			end
		end
		if (state_q == S_FIX) begin
			free_mem[SW'(free_top_q)] <= cur_q;
			if (req_q.kind == bdll_pkg::KIND_DEL_AT && req_q.position != '0 &&
					CW'(req_q.position) != cnt_q - CW'(1)) begin
				fwd_mem[rd_bwd] <= rd_fwd;
				bwd_mem[rd_fwd] <= rd_bwd;
			end
		end
	end

	`ASSERT_ALW(a_count_sum, clk, arst_n, cnt_q + free_top_q == CW'(bdll_pkg::Capacity))
	`ASSERT_IMP(a_fix_nonempty, clk, arst_n, state_q == S_FIX, cnt_q != '0)
	`ASSERT_IMP(a_dump_steps, clk, arst_n, state_q == S_DUMP, step_q != '0 && step_q <= cnt_q)
endmodule

@@ rtl/core/bounded_doubly_linked_list.sv @@
// top level of the bounded doubly linked list
// Each request is one list operation; it passes a two-entry intake queue before
// the list engine. In the engine an insert goes from idle straight to its result,
// a delete at either end passes the unlink state first, and a delete in the
// middle walks the forward links one per cycle before the unlink state; a dump
// streams one entry per reply taken. A result that is not taken holds the
// engine while it waits. After reset the free-slot stack is filled before the
// engine takes the first request.
`timescale 1ns / 1ps
module bounded_doubly_linked_list (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] kind,
	input logic signed [31:0] value,
	input logic [3:0] position,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic signed [31:0] element,
	output logic [4:0] count,
	output logic last
);
	bdll_pkg::req_t in_req, q_req;
	logic q_valid, q_ready;

	assign in_req = '{kind: kind, value: value, position: position};

	// intake queue
	bdll_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	// list engine
	bdll_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_req(q_req), .out_valid(out_valid), .out_ready(out_ready),
		.status(status), .element(element), .count(count), .last(last)
	);
endmodule

@@ tb/tb.sv @@
// self-checking testbench of the bounded doubly linked list
`timescale 1ns / 1ps
module tb;
	localparam int WatchLimit = 4000;

	typedef struct {
		logic [2:0] kind;
		logic signed [31:0] value;
		logic [3:0] position;
	} list_op_t;

	typedef struct {
		logic [1:0] status;
		logic signed [31:0] element;
		logic [4:0] count;
		logic last;
	} list_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] kind = '0;
	logic signed [31:0] value = '0;
	logic [3:0] position = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic signed [31:0] element;
	logic [4:0] count;
	logic last;

	list_op_t pending_ops[$];
	list_reply_t expected_replies[$];
	int error_count = 0;
	int idle_cycles = 0;
	int cycle_no = 0;
	bit stim_done = 1'b0;
	logic in_ready_seen = 1'b0;

	// shadow copy of the list kept as an ordered queue of values
	logic signed [31:0] shadow_list[$];

	bounded_doubly_linked_list dut (.*);

	always #4 clk = ~clk;

	// predict the replies of one accepted request
	task automatic predict_op(input list_op_t op);
		list_reply_t r;
		int n;
		r.status = bdll_pkg::ST_OK;
		r.element = '0;
		r.last = 1'b1;
		n = shadow_list.size();
		case (op.kind)
			bdll_pkg::KIND_INS_HEAD, bdll_pkg::KIND_INS_TAIL: begin
				if (n >= bdll_pkg::Capacity)
					r.status = bdll_pkg::ST_FULL;
				else if (op.kind == bdll_pkg::KIND_INS_HEAD)
					shadow_list.push_front(op.value);
				else
					shadow_list.push_back(op.value);
			end
			bdll_pkg::KIND_DEL_HEAD, bdll_pkg::KIND_DEL_TAIL: begin
				if (n == 0)
					r.status = bdll_pkg::ST_EMPTY;
				else if (op.kind == bdll_pkg::KIND_DEL_HEAD)
					void'(shadow_list.pop_front());
				else
					void'(shadow_list.pop_back());
			end
			bdll_pkg::KIND_DEL_AT: begin
				if (n == 0)
					r.status = bdll_pkg::ST_EMPTY;
				else if (op.position >= n)
					r.status = bdll_pkg::ST_RANGE;
				else
					shadow_list.delete(op.position);
			end
			bdll_pkg::KIND_DUMP_FWD, bdll_pkg::KIND_DUMP_BWD: begin
				if (n == 0)
					r.status = bdll_pkg::ST_EMPTY;
				else begin
					for (int i = 0; i < n; i++) begin
						r.element = (op.kind == bdll_pkg::KIND_DUMP_FWD) ? shadow_list[i]
							: shadow_list[n - 1 - i];
						r.count = 5'(n);
						r.last = (i == n - 1);
						expected_replies.push_back(r);
					end
					return;
				end
			end
			default: ;
		endcase
		r.count = 5'(shadow_list.size());
		expected_replies.push_back(r);
	endtask

	function automatic list_op_t make_op(input logic [2:0] k, input logic signed [31:0] v,
		input logic [3:0] p);
		list_op_t op;
		op.kind = k;
		op.value = v;
		op.position = p;
		return op;
	endfunction

	// random request weighted by the phase: mostly inserts, then mostly deletes, then uniform
	function automatic list_op_t random_op(input int phase);
		int w;
		logic [2:0] k;
		w = $urandom_range(99);
		if (phase == 0)
			k = (w < 60) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
		else if (phase == 1)
			k = (w < 55) ? 3'($urandom_range(4, 2)) : 3'($urandom_range(7));
		else
			k = 3'($urandom_range(7));
		return make_op(k, $urandom, 4'($urandom_range(15)));
	endfunction

	function automatic bit quiet_stretch();
		return cycle_no >= 600 && cycle_no < 1400;
	endfunction

	// stimulus: directed part then random phases
	initial begin
		pending_ops.push_back(make_op(bdll_pkg::KIND_DEL_HEAD, 32'sd0, 4'd0));
		pending_ops.push_back(make_op(bdll_pkg::KIND_DEL_TAIL, 32'sd0, 4'd0));
		pending_ops.push_back(make_op(bdll_pkg::KIND_DEL_AT, 32'sd0, 4'd0));
		pending_ops.push_back(make_op(bdll_pkg::KIND_DUMP_FWD, 32'sd0, 4'd0));
		pending_ops.push_back(make_op(bdll_pkg::KIND_DUMP_BWD, 32'sd0, 4'd0));
		pending_ops.push_back(make_op(3'd7, 32'sd0, 4'hf));
		pending_ops.push_back(make_op(bdll_pkg::KIND_INS_HEAD, 32'sh7fffffff, 4'd0));
		pending_ops.push_back(make_op(bdll_pkg::KIND_INS_TAIL, 32'sh80000000, 4'd0));
		pending_ops.push_back(make_op(bdll_pkg::KIND_INS_HEAD, -32'sd1, 4'd0));
		pending_ops.push_back(make_op(bdll_pkg::KIND_DEL_AT, 32'sd0, 4'd15));
		pending_ops.push_back(make_op(bdll_pkg::KIND_DUMP_FWD, 32'sd0, 4'd0));
		pending_ops.push_back(make_op(bdll_pkg::KIND_DEL_AT, 32'sd0, 4'd1));
		pending_ops.push_back(make_op(bdll_pkg::KIND_DUMP_BWD, 32'sd0, 4'd0));
		for (int i = 0; i < 16; i++)
			pending_ops.push_back(make_op(bdll_pkg::KIND_INS_TAIL, i * 1000 - 3, 4'd0));
		pending_ops.push_back(make_op(bdll_pkg::KIND_INS_HEAD, 32'sd5, 4'd0));
		pending_ops.push_back(make_op(bdll_pkg::KIND_DEL_AT, 32'sd0, 4'd15));
		pending_ops.push_back(make_op(bdll_pkg::KIND_DEL_AT, 32'sd0, 4'd7));
		pending_ops.push_back(make_op(bdll_pkg::KIND_DUMP_FWD, 32'sd0, 4'd0));
		for (int i = 0; i < 180; i++)
			pending_ops.push_back(random_op((i / 25) % 3));
		stim_done = 1'b1;
	end

	// reset
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// request driver, long quiet stretch in the middle of the run
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready_seen) begin
				if (pending_ops.size() > 0 &&
					(quiet_stretch() || $urandom_range(99) >= 19)) begin
					kind <= pending_ops[0].kind;
					value <= pending_ops[0].value;
					position <= pending_ops[0].position;
					in_valid <= 1'b1;
					void'(pending_ops.pop_front());
				end else
					in_valid <= 1'b0;
			end
			out_ready <= quiet_stretch() || ($urandom_range(99) >= 19);
		end
	end

	// monitor: requests and replies sampled at the rising edge
	always @(posedge clk) begin
		list_reply_t e;
		cycle_no <= cycle_no + 1;
		in_ready_seen <= in_valid && in_ready;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (in_valid && in_ready)
				predict_op(make_op(kind, value, position));
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					error_count <= error_count + 1;
					$display("%0t: reply with none expected: status %0d element %0d",
						$time, status, element);
				end else begin
					e = expected_replies.pop_front();
					if (status !== e.status || element !== e.element ||
						count !== e.count || last !== e.last) begin
						error_count <= error_count + 1;
						$display("%0t: mismatch exp st %0d el %0d cnt %0d last %0d",
							$time, e.status, e.element, e.count, e.last);
						$display("%0t:          act st %0d el %0d cnt %0d last %0d",
							$time, status, element, count, last);
					end
				end
			end
		end
	end

	// end of run and watchdog
	initial begin
		wait (arst_n);
		while (!(stim_done && pending_ops.size() == 0 && !in_valid &&
			expected_replies.size() == 0) && idle_cycles < WatchLimit)
			@(posedge clk);
		if (idle_cycles >= WatchLimit) begin
			$display("Testbench completed WITH ERRORS");
		end else begin
			repeat (40) @(posedge clk);
			if (error_count == 0)
				$display("Testbench completed without errors");
			else
				$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/bdll_pkg.sv
rtl/core/bdll_front.sv
rtl/core/bdll_back.sv
rtl/core/bounded_doubly_linked_list.sv
tb/tb.sv
